[hw/rtl/cfa_pkg.sv]
`default_nettype none

package cfa_pkg;

    // word width of the alu and port field widths
    localparam int WIDTH_DEFAULT = 16;
    localparam int CMD_W         = 5;
    localparam int OPND_W        = 16;
    localparam int RES_W         = 16;
    localparam int QUEUE_DEPTH   = 4;

    // opcodes
    localparam logic [CMD_W-1:0] OP_ADD  = 5'd0;
    localparam logic [CMD_W-1:0] OP_SUB  = 5'd1;
    localparam logic [CMD_W-1:0] OP_MUL  = 5'd2;
    localparam logic [CMD_W-1:0] OP_DIV  = 5'd3;
    localparam logic [CMD_W-1:0] OP_MOD  = 5'd4;
    localparam logic [CMD_W-1:0] OP_EQ   = 5'd5;
    localparam logic [CMD_W-1:0] OP_NE   = 5'd6;
    localparam logic [CMD_W-1:0] OP_LE   = 5'd7;
    localparam logic [CMD_W-1:0] OP_GE   = 5'd8;
    localparam logic [CMD_W-1:0] OP_LT   = 5'd9;
    localparam logic [CMD_W-1:0] OP_GT   = 5'd10;
    localparam logic [CMD_W-1:0] OP_AND  = 5'd11;
    localparam logic [CMD_W-1:0] OP_OR   = 5'd12;
    localparam logic [CMD_W-1:0] OP_XOR  = 5'd13;
    localparam logic [CMD_W-1:0] OP_ASR  = 5'd14;
    localparam logic [CMD_W-1:0] OP_ASL  = 5'd15;
    localparam logic [CMD_W-1:0] OP_UMUL = 5'd16;
    localparam logic [CMD_W-1:0] OP_UDIV = 5'd17;
    localparam logic [CMD_W-1:0] OP_UMOD = 5'd18;
    localparam logic [CMD_W-1:0] OP_ULE  = 5'd19;
    localparam logic [CMD_W-1:0] OP_UGE  = 5'd20;
    localparam logic [CMD_W-1:0] OP_ULT  = 5'd21;
    localparam logic [CMD_W-1:0] OP_UGT  = 5'd22;

    // what the back end has to do with an item
    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_MUL,
        KIND_DIV,
        KIND_MOD
    } cfa_kind_t;

    // control travelling with an item from front to back
    typedef struct packed {
        cfa_kind_t kind;
        logic      negate;
        logic      dz;
    } cfa_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/cfa_front.sv]
`default_nettype none

module cfa_front #(
    parameter int WIDTH = cfa_pkg::WIDTH_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [cfa_pkg::CMD_W-1:0]  in_cmd,
    input  wire logic [cfa_pkg::OPND_W-1:0] in_left,
    input  wire logic [cfa_pkg::OPND_W-1:0] in_right,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output cfa_pkg::cfa_ctrl_t            out_ctrl,
    output logic [WIDTH-1:0]              out_x,
    output logic [WIDTH-1:0]              out_y,
    output logic [WIDTH-1:0]              out_res
);

    logic               valid_reg;
    cfa_pkg::cfa_ctrl_t ctrl_reg, ctrl_next;
    logic [WIDTH-1:0]   x_reg, x_next;
    logic [WIDTH-1:0]   y_reg, y_next;
    logic [WIDTH-1:0]   res_reg, res_next;

    logic [WIDTH-1:0]   a, b, mag_a, mag_b;
    logic               b_zero, slt_ab, slt_ba;

    // operand prep: low word bits, magnitudes, signed compares
    always_comb begin
        a      = WIDTH'(in_left);
        b      = WIDTH'(in_right);
        mag_a  = a[WIDTH-1] ? WIDTH'((~a) + WIDTH'(1)) : a;
        mag_b  = b[WIDTH-1] ? WIDTH'((~b) + WIDTH'(1)) : b;
        b_zero = (b == '0);
        slt_ab = ($signed(a) < $signed(b));
        slt_ba = ($signed(b) < $signed(a));
    end

    // classify: simple ops and divide by zero finish here, mul/div/mod go to the back end
    always_comb begin
        ctrl_next.kind   = cfa_pkg::KIND_PASS;
        ctrl_next.negate = 1'b0;
        ctrl_next.dz     = 1'b0;
        x_next           = a;
        y_next           = b;
        res_next         = '0;
        case (in_cmd)
            cfa_pkg::OP_ADD: begin
                res_next = WIDTH'(a + b);
            end
            cfa_pkg::OP_SUB: begin
                res_next = WIDTH'(a - b);
            end
            cfa_pkg::OP_MUL, cfa_pkg::OP_UMUL: begin
                ctrl_next.kind = cfa_pkg::KIND_MUL;
            end
            cfa_pkg::OP_DIV: begin
                if (b_zero) begin
                    ctrl_next.dz = 1'b1;
                    res_next     = '1;
                end else begin
                    ctrl_next.kind   = cfa_pkg::KIND_DIV;
                    ctrl_next.negate = a[WIDTH-1] ^ b[WIDTH-1];
                    x_next           = mag_a;
                    y_next           = mag_b;
                end
            end
            cfa_pkg::OP_MOD: begin
                if (b_zero) begin
                    ctrl_next.dz = 1'b1;
                    res_next     = a;
                end else begin
                    ctrl_next.kind   = cfa_pkg::KIND_MOD;
                    ctrl_next.negate = a[WIDTH-1];
                    x_next           = mag_a;
                    y_next           = mag_b;
                end
            end
            cfa_pkg::OP_EQ:  res_next = WIDTH'(a == b);
            cfa_pkg::OP_NE:  res_next = WIDTH'(a != b);
            cfa_pkg::OP_LE:  res_next = WIDTH'(!slt_ba);
            cfa_pkg::OP_GE:  res_next = WIDTH'(!slt_ab);
            cfa_pkg::OP_LT:  res_next = WIDTH'(slt_ab);
            cfa_pkg::OP_GT:  res_next = WIDTH'(slt_ba);
            cfa_pkg::OP_AND: res_next = a & b;
            cfa_pkg::OP_OR:  res_next = a | b;
            cfa_pkg::OP_XOR: res_next = a ^ b;
            // shifts of width or more already fill with sign or zero
            cfa_pkg::OP_ASR: res_next = $unsigned($signed(a) >>> b);
            cfa_pkg::OP_ASL: res_next = a << b;
            cfa_pkg::OP_UDIV: begin
                if (b_zero) begin
                    ctrl_next.dz = 1'b1;
                    res_next     = '1;
                end else begin
                    ctrl_next.kind = cfa_pkg::KIND_DIV;
                end
            end
            cfa_pkg::OP_UMOD: begin
                if (b_zero) begin
                    ctrl_next.dz = 1'b1;
                    res_next     = a;
                end else begin
                    ctrl_next.kind = cfa_pkg::KIND_MOD;
                end
            end
            cfa_pkg::OP_ULE: res_next = WIDTH'(a <= b);
            cfa_pkg::OP_UGE: res_next = WIDTH'(a >= b);
            cfa_pkg::OP_ULT: res_next = WIDTH'(a < b);
            cfa_pkg::OP_UGT: res_next = WIDTH'(a > b);
            default:         res_next = '0;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctrl_reg <= ctrl_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            res_reg  <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

[hw/rtl/cfa_queue.sv]
`default_nettype none

module cfa_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = cfa_pkg::QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : PTR_W'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop) begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end else if (pop && !push) begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

endmodule

`default_nettype wire

[hw/rtl/cfa_back.sv]
`default_nettype none

module cfa_back #(
    parameter int WIDTH = cfa_pkg::WIDTH_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire cfa_pkg::cfa_ctrl_t       in_ctrl,
    input  wire logic [WIDTH-1:0]         in_x,
    input  wire logic [WIDTH-1:0]         in_y,
    input  wire logic [WIDTH-1:0]         in_res,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [cfa_pkg::RES_W-1:0]     out_word,
    output logic                          out_dz
);

    // stage 0 is the entry register, stage k holds an item after k steps
    logic [WIDTH:0]     v_reg;
    cfa_pkg::cfa_ctrl_t ctrl_reg [WIDTH+1];
    logic [WIDTH-1:0]   x_reg    [WIDTH+1];
    logic [WIDTH-1:0]   y_reg    [WIDTH+1];
    logic [WIDTH-1:0]   acc_reg  [WIDTH+1];
    logic [WIDTH-1:0]   rem_reg  [WIDTH+1];
    logic [WIDTH-1:0]   res_reg  [WIDTH+1];

    logic [WIDTH-1:0]   x_next   [WIDTH+1];
    logic [WIDTH-1:0]   y_next   [WIDTH+1];
    logic [WIDTH-1:0]   acc_next [WIDTH+1];
    logic [WIDTH-1:0]   rem_next [WIDTH+1];

    logic                      out_valid_reg;
    logic [cfa_pkg::RES_W-1:0] out_word_reg, out_word_next;
    logic                      out_dz_reg;
    logic                      adv;
    logic [WIDTH-1:0]          fin_val;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // one shift-add multiply step or one restoring divide step per stage
    always_comb begin
        logic [WIDTH:0] t;
        logic           ge;
        x_next[0]   = in_x;
        y_next[0]   = in_y;
        acc_next[0] = '0;
        rem_next[0] = '0;
        for (int k = 1; k <= WIDTH; k++) begin
            t           = '0;
            ge          = 1'b0;
            x_next[k]   = x_reg[k-1];
            y_next[k]   = y_reg[k-1];
            acc_next[k] = acc_reg[k-1];
            rem_next[k] = rem_reg[k-1];
            case (ctrl_reg[k-1].kind)
                cfa_pkg::KIND_MUL: begin
                    if (y_reg[k-1][0]) begin
                        acc_next[k] = WIDTH'(acc_reg[k-1] + x_reg[k-1]);
                    end
                    x_next[k] = x_reg[k-1] << 1;
                    y_next[k] = y_reg[k-1] >> 1;
                end
                cfa_pkg::KIND_DIV, cfa_pkg::KIND_MOD: begin
                    t  = {rem_reg[k-1], x_reg[k-1][WIDTH-1]};
                    ge = (t >= {1'b0, y_reg[k-1]});
                    rem_next[k] = ge ? WIDTH'(t - {1'b0, y_reg[k-1]}) : t[WIDTH-1:0];
                    acc_next[k] = {acc_reg[k-1][WIDTH-2:0], ge};
                    x_next[k]   = x_reg[k-1] << 1;
                end
                default: begin
                end
            endcase
        end
    end

    // pick the result of the last stage and fix its sign
    always_comb begin
        case (ctrl_reg[WIDTH].kind)
            cfa_pkg::KIND_MUL: fin_val = acc_reg[WIDTH];
            cfa_pkg::KIND_DIV: fin_val = acc_reg[WIDTH];
            cfa_pkg::KIND_MOD: fin_val = rem_reg[WIDTH];
            default:           fin_val = res_reg[WIDTH];
        endcase
        if (ctrl_reg[WIDTH].negate) begin
            fin_val = WIDTH'((~fin_val) + WIDTH'(1));
        end
        out_word_next = cfa_pkg::RES_W'(fin_val);
    end

    // stage valids, the whole pipe holds while the output is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v_reg         <= {v_reg[WIDTH-1:0], in_valid};
            out_valid_reg <= v_reg[WIDTH];
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            ctrl_reg[0] <= in_ctrl;
            res_reg[0]  <= in_res;
            for (int k = 1; k <= WIDTH; k++) begin
                ctrl_reg[k] <= ctrl_reg[k-1];
                res_reg[k]  <= res_reg[k-1];
            end
            for (int k = 0; k <= WIDTH; k++) begin
                x_reg[k]   <= x_next[k];
                y_reg[k]   <= y_next[k];
                acc_reg[k] <= acc_next[k];
                rem_reg[k] <= rem_next[k];
            end
            out_word_reg <= out_word_next;
            out_dz_reg   <= ctrl_reg[WIDTH].dz;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_dz    = out_dz_reg;

    a_entry_load: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && adv |=> v_reg[0])
        else $error("accepted item missing from entry stage");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(v_reg) && out_valid_reg)
        else $error("pipeline moved during output stall");

    a_dz_is_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[0] && ctrl_reg[0].dz |-> ctrl_reg[0].kind == cfa_pkg::KIND_PASS)
        else $error("divide by zero item sent to arithmetic steps");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_ready |=> out_valid_reg == $past(v_reg[WIDTH]))
        else $error("output valid does not follow last stage");

endmodule

`default_nettype wire

[hw/rtl/constant_folding_alu_unit.sv]
// constant folding alu: a stateless integer alu on WIDTH-bit words
//
// input channel s_*: one item per handshake, opcode in s_tuser, the two
// operand words in s_tdata. result channel m_*: result word in m_tdata,
// divide-by-zero flag in m_tuser. every item gives exactly one result,
// in order.
//
// throughput: one item per cycle while the output is not stalled. a result
// passes the front register, the queue, the multiply/divide pipe of
// WIDTH steps, one product bit or one quotient bit per stage, and the
// output register.
//
// the front classifies and finishes the simple operations and feeds a
// small queue; the back pipe freezes as a whole while a result waits in
// the output register with m_tready low, and the front keeps taking
// items until the queue and its own register fill.
// reset (aresetn low, synchronous) empties the front, queue and pipe.
`default_nettype none

module constant_folding_alu_unit #(
    parameter int WIDTH       = cfa_pkg::WIDTH_DEFAULT,
    parameter int QUEUE_DEPTH = cfa_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] left_operand, [31:16] right_operand
    input  wire logic [4:0]  s_tuser,   // [4:0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] result_word
    output logic [0:0]       m_tuser    // [0] divide_by_zero
);

    localparam int CTRL_W = $bits(cfa_pkg::cfa_ctrl_t);
    localparam int QW     = CTRL_W + 3 * WIDTH;

    logic               f_valid, f_ready;
    cfa_pkg::cfa_ctrl_t f_ctrl;
    logic [WIDTH-1:0]   f_x, f_y, f_res;

    logic               q_valid, q_ready;
    logic [QW-1:0]      q_out;
    cfa_pkg::cfa_ctrl_t q_ctrl;

    logic               b_dz;

    // front: accept and classify
    cfa_front #(
        .WIDTH (WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_left   (s_tdata[15:0]),
        .in_right  (s_tdata[31:16]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_ctrl  (f_ctrl),
        .out_x     (f_x),
        .out_y     (f_y),
        .out_res   (f_res)
    );

    // queue between front and back
    cfa_queue #(
        .DATA_W (QW),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_ctrl, f_x, f_y, f_res}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_out)
    );

    assign q_ctrl = cfa_pkg::cfa_ctrl_t'(q_out[QW-1 -: CTRL_W]);

    // back: multiply/divide pipe and output register
    cfa_back #(
        .WIDTH (WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_ctrl   (q_ctrl),
        .in_x      (q_out[3*WIDTH-1 -: WIDTH]),
        .in_y      (q_out[2*WIDTH-1 -: WIDTH]),
        .in_res    (q_out[WIDTH-1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata),
        .out_dz    (b_dz)
    );

    assign m_tuser = b_dz;

endmodule

`default_nettype wire

[bench/constant_folding_alu_unit_tb.sv]
`default_nettype none

module constant_folding_alu_unit_tb;

    import cfa_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 700;
    localparam int HOLD_CYCLES   = 80;
    localparam int HOLD_ITEMS    = 40;
    localparam int DRAIN_CYCLES  = 40;
    localparam int IDLE_PERCENT  = 18;

    // codes with no operation behind them
    localparam logic [CMD_W-1:0] OP_FIRST_UNKNOWN = 5'd23;
    localparam logic [CMD_W-1:0] OP_LAST_UNKNOWN  = 5'd31;

    typedef struct packed {
        logic [RES_W-1:0] word;
        logic             dz;
    } alu_result_t;

    // expected results in order, folded from each accepted item
    class alu_scoreboard;
        alu_result_t pending_q[$];
        int          errors;
        int          checked;
        int          dz_seen;

        function new();
            errors  = 0;
            checked = 0;
            dz_seen = 0;
        endfunction

        function alu_result_t fold(logic [CMD_W-1:0] op, logic [OPND_W-1:0] a,
                                   logic [OPND_W-1:0] b);
            alu_result_t      r;
            logic [OPND_W-1:0] mag_a;
            logic [OPND_W-1:0] mag_b;
            logic [OPND_W-1:0] quo;
            logic [OPND_W-1:0] rem;
            r.word = '0;
            r.dz   = 1'b0;
            mag_a  = a[15] ? (~a + 16'd1) : a;
            mag_b  = b[15] ? (~b + 16'd1) : b;
            case (op)
                OP_ADD: r.word = a + b;
                OP_SUB: r.word = a - b;
                OP_MUL, OP_UMUL: r.word = a * b;
                OP_DIV: begin
                    if (b == '0) begin
                        r.dz   = 1'b1;
                        r.word = '1;
                    end else begin
                        // truncate toward zero, sign from both operands
                        quo    = mag_a / mag_b;
                        r.word = (a[15] ^ b[15]) ? (~quo + 16'd1) : quo;
                    end
                end
                OP_MOD: begin
                    if (b == '0) begin
                        r.dz   = 1'b1;
                        r.word = a;
                    end else begin
                        // remainder follows the dividend sign
                        rem    = mag_a % mag_b;
                        r.word = a[15] ? (~rem + 16'd1) : rem;
                    end
                end
                OP_EQ:  r.word = {15'd0, a == b};
                OP_NE:  r.word = {15'd0, a != b};
                OP_LE:  r.word = {15'd0, $signed(a) <= $signed(b)};
                OP_GE:  r.word = {15'd0, $signed(a) >= $signed(b)};
                OP_LT:  r.word = {15'd0, $signed(a) < $signed(b)};
                OP_GT:  r.word = {15'd0, $signed(a) > $signed(b)};
                OP_AND: r.word = a & b;
                OP_OR:  r.word = a | b;
                OP_XOR: r.word = a ^ b;
                OP_ASR: begin
                    if (b >= 16'd16)
                        r.word = {16{a[15]}};
                    else
                        r.word = $signed(a) >>> b[3:0];
                end
                OP_ASL: r.word = (b >= 16'd16) ? 16'd0 : (a << b[3:0]);
                OP_UDIV: begin
                    if (b == '0) begin
                        r.dz   = 1'b1;
                        r.word = '1;
                    end else begin
                        r.word = a / b;
                    end
                end
                OP_UMOD: begin
                    if (b == '0) begin
                        r.dz   = 1'b1;
                        r.word = a;
                    end else begin
                        r.word = a % b;
                    end
                end
                OP_ULE: r.word = {15'd0, a <= b};
                OP_UGE: r.word = {15'd0, a >= b};
                OP_ULT: r.word = {15'd0, a < b};
                OP_UGT: r.word = {15'd0, a > b};
                default: r.word = '0;
            endcase
            return r;
        endfunction

        function void note_item(logic [CMD_W-1:0] op, logic [OPND_W-1:0] a,
                                logic [OPND_W-1:0] b);
            pending_q.push_back(fold(op, a, b));
        endfunction

        function void check_result(logic [RES_W-1:0] word, logic dz);
            alu_result_t want;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending: word %h dz %b",
                         $time, word, dz);
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (dz)
                dz_seen++;
            if (want.word !== word) begin
                errors++;
                $display("%0t: result_word mismatch: expected %h actual %h",
                         $time, want.word, word);
            end
            if (want.dz !== dz) begin
                errors++;
                $display("%0t: divide_by_zero mismatch: expected %b actual %b",
                         $time, want.dz, dz);
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [4:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    alu_scoreboard sb;
    bit            tx_idle_en;
    bit            rx_idle_en;
    bit            hold_req;
    int            cycle_count;
    int            items_sent;

    constant_folding_alu_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // watch both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser[0]);
            if (s_tvalid && s_tready)
                sb.note_item(s_tuser, s_tdata[15:0], s_tdata[31:16]);
        end
    end

    // result side: random stalls, or a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(99) < IDLE_PERCENT) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // offer one item at a falling edge and hold it until taken
    task automatic send_item(input logic [CMD_W-1:0] op, input logic [OPND_W-1:0] a,
                             input logic [OPND_W-1:0] b);
        while (tx_idle_en && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= op;
        do
            @(posedge aclk);
        while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    // operand mix weighted toward corner values and small shift amounts
    function automatic logic [OPND_W-1:0] pick_operand();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'($urandom_range(1, 20));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random();
        logic [CMD_W-1:0]  op;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
        if ($urandom_range(19) == 0)
            op = 5'($urandom_range(OP_FIRST_UNKNOWN, OP_LAST_UNKNOWN));
        else
            op = 5'($urandom_range(OP_ADD, OP_UGT));
        a = pick_operand();
        b = pick_operand();
        send_item(op, a, b);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(negedge aclk);
    endtask

    // main sequence
    initial begin
        sb          = new();
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        hold_req    = 1'b0;
        cycle_count = 0;
        items_sent  = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: each opcode at least once, with the corner cases
        send_item(OP_ADD,  16'h7FFF, 16'h0001);
        send_item(OP_SUB,  16'h8000, 16'h0001);
        send_item(OP_MUL,  16'hFFFF, 16'hFFFF);
        send_item(OP_DIV,  16'h8000, 16'hFFFF);
        send_item(OP_MOD,  16'h8000, 16'hFFFF);
        send_item(OP_MOD,  16'h8001, 16'h0000);
        send_item(OP_EQ,   16'h8000, 16'h8000);
        send_item(OP_NE,   16'h0000, 16'hFFFF);
        send_item(OP_LE,   16'hFFFF, 16'h0001);
        send_item(OP_GE,   16'h8000, 16'h7FFF);
        send_item(OP_LT,   16'h8000, 16'h7FFF);
        send_item(OP_GT,   16'h7FFF, 16'h8000);
        send_item(OP_AND,  16'hA5A5, 16'hFFFF);
        send_item(OP_OR,   16'h5A5A, 16'hA5A5);
        send_item(OP_XOR,  16'hFFFF, 16'h00FF);
        send_item(OP_ASR,  16'h8000, 16'h0010);
        send_item(OP_ASL,  16'hFFFF, 16'h000F);
        send_item(OP_UMUL, 16'hFFFF, 16'h0002);
        send_item(OP_UDIV, 16'hFFFF, 16'h0000);
        send_item(OP_UMOD, 16'h0007, 16'h0000);
        send_item(OP_ULE,  16'hFFFF, 16'h0001);
        send_item(OP_UGE,  16'h0000, 16'hFFFF);
        send_item(OP_ULT,  16'h0000, 16'hFFFF);
        send_item(OP_UGT,  16'hFFFF, 16'h8000);
        send_item(OP_LAST_UNKNOWN, 16'hFFFF, 16'hFFFF);

        // random with stalls on both sides
        repeat (RANDOM_ITEMS / 3) send_random();

        // long stretch at full rate
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (RANDOM_ITEMS / 4) send_random();

        // hold the result side off so the block backs up into its input
        hold_req = 1'b1;
        repeat (HOLD_ITEMS) send_random();
        s_tvalid <= 1'b0;
        wait_drained();
        @(negedge aclk);

        // rest with stalls again
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (RANDOM_ITEMS - RANDOM_ITEMS / 3 - RANDOM_ITEMS / 4 - HOLD_ITEMS)
            send_random();
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("run: %0d items over every opcode and unknown codes, %0d results checked",
                 items_sent, sb.checked);
        $display("run: %0d divide-by-zero results, random stalls, a full-rate stretch, %s",
                 sb.dz_seen, "an output hold-off and a drain pause");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/cfa_pkg.sv
hw/rtl/cfa_front.sv
hw/rtl/cfa_queue.sv
hw/rtl/cfa_back.sv
hw/rtl/constant_folding_alu_unit.sv
bench/constant_folding_alu_unit_tb.sv
